[rtl/ordi_pkg.sv]
// ----------------------------------------------------------------------------
// ordi_pkg
// Shared types, constants and arithmetic for the ordered-dither palette lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ordi_pkg;

  localparam int PALETTE_INDEX_BITS = 9;
  localparam int TABLE_ADDR_BITS    = 9;
  localparam int TABLE_DEPTH        = 1 << TABLE_ADDR_BITS;
  localparam int LEVELS_BITS        = 7;
  localparam int CHAN_BITS          = 8;
  localparam int SHADE_BITS         = 3;
  localparam int APB_ADDR_BITS      = 3;
  localparam int APB_DATA_BITS      = 32;

  localparam logic [PALETTE_INDEX_BITS-1:0] INDEX_MASK = '1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // register index, taken from paddr above the byte lanes
  localparam logic REG_INTENSITY_LEVELS = 1'b0;

  localparam logic [SHADE_BITS-1:0] SHADE_MAX = '1;

  typedef logic [TABLE_ADDR_BITS-1:0]    table_addr_t;
  typedef logic [PALETTE_INDEX_BITS-1:0] palette_index_t;

  typedef struct packed {
    logic           en;
    table_addr_t    addr;
    palette_index_t data;
  } table_wr_t;

  function automatic logic [3:0] bayer_threshold(input logic [3:0] pos);
    logic [3:0] th;
    unique case (pos)
      4'd0:  th = 4'd0;
      4'd1:  th = 4'd8;
      4'd2:  th = 4'd2;
      4'd3:  th = 4'd10;
      4'd4:  th = 4'd12;
      4'd5:  th = 4'd4;
      4'd6:  th = 4'd14;
      4'd7:  th = 4'd6;
      4'd8:  th = 4'd3;
      4'd9:  th = 4'd11;
      4'd10: th = 4'd1;
      4'd11: th = 4'd9;
      4'd12: th = 4'd15;
      4'd13: th = 4'd7;
      4'd14: th = 4'd13;
      4'd15: th = 4'd5;
      default: th = 4'd0;
    endcase
    return th;
  endfunction

  function automatic logic [SHADE_BITS-1:0] shade_of(
    input logic [CHAN_BITS-1:0]   comp,
    input logic [LEVELS_BITS-1:0] levels,
    input logic [3:0]             th
  );
    logic [CHAN_BITS+LEVELS_BITS-1:0] product;
    logic [LEVELS_BITS-1:0]           scaled;
    logic [SHADE_BITS:0]              shade;
    product = comp * levels;
    scaled  = product[CHAN_BITS+LEVELS_BITS-1:CHAN_BITS];
    shade   = {1'b0, scaled[LEVELS_BITS-1:4]};
    if (scaled[3:0] > th) begin
      shade = shade + 1'b1;
    end
    if (shade > {1'b0, SHADE_MAX}) begin
      shade = {1'b0, SHADE_MAX};
    end
    return shade[SHADE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ordered_dither_palette_index.sv]
// ----------------------------------------------------------------------------
// ordered_dither_palette_index
// 4x4 ordered dither of RGB pixels into a stored colour-to-palette table.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while in_stall is low. A pixel scales,
// dithers and packs its shades in the accept cycle; the table read is registered
// at the accepting edge and palette_index is loaded from it when the output can
// load. A table write is stored at the accept edge and gives no result. After
// reset the table is swept to zero, one entry a cycle, during which in_stall is
// held high; configuration writes are taken throughout.
`default_nettype none

module ordered_dither_palette_index (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [ordi_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  wire logic [ordi_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [ordi_pkg::APB_DATA_BITS-1:0]         prdata,
  output logic                                       pready,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  mode,
  input  wire logic [15:0]                           x_pos,
  input  wire logic [15:0]                           y_pos,
  input  wire logic [ordi_pkg::CHAN_BITS-1:0]        red_in,
  input  wire logic [ordi_pkg::CHAN_BITS-1:0]        green_in,
  input  wire logic [ordi_pkg::CHAN_BITS-1:0]        blue_in,
  input  wire logic [ordi_pkg::TABLE_ADDR_BITS-1:0]  entry_address,
  input  wire logic [ordi_pkg::PALETTE_INDEX_BITS-1:0] entry_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [ordi_pkg::PALETTE_INDEX_BITS-1:0]    palette_index
);

  logic [ordi_pkg::LEVELS_BITS-1:0] intensity_levels;
  logic                             cfg_write;

  logic                             in_accept;
  logic                             pixel_accept;
  logic                             table_busy;
  logic [3:0]                       threshold;
  logic [ordi_pkg::SHADE_BITS-1:0]  shade_r;
  logic [ordi_pkg::SHADE_BITS-1:0]  shade_g;
  logic [ordi_pkg::SHADE_BITS-1:0]  shade_b;
  ordi_pkg::table_addr_t            rd_addr;
  ordi_pkg::palette_index_t         rd_data;
  ordi_pkg::table_wr_t              wr;

  logic                             read_valid;
  logic                             read_move;
  logic                             out_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == ordi_pkg::REG_INTENSITY_LEVELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity_levels <= '0;
    end else if (cfg_write) begin
      intensity_levels <= pwdata[ordi_pkg::LEVELS_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ordi_pkg::REG_INTENSITY_LEVELS) begin
      prdata[ordi_pkg::LEVELS_BITS-1:0] = intensity_levels;
    end
  end

  assign out_load     = !out_valid || !out_stall;
  assign read_move    = read_valid && out_load;
  assign in_stall     = table_busy || (read_valid && !out_load);
  assign in_accept    = in_valid && !in_stall;
  assign pixel_accept = in_accept && (mode == ordi_pkg::MODE_PIXEL);

  assign threshold = ordi_pkg::bayer_threshold({y_pos[1:0], x_pos[1:0]});
  assign shade_r   = ordi_pkg::shade_of(red_in,   intensity_levels, threshold);
  assign shade_g   = ordi_pkg::shade_of(green_in, intensity_levels, threshold);
  assign shade_b   = ordi_pkg::shade_of(blue_in,  intensity_levels, threshold);
  assign rd_addr   = {shade_b, shade_g, shade_r};

  always_comb begin
    wr.en   = in_accept && (mode == ordi_pkg::MODE_WRITE);
    wr.addr = entry_address;
    wr.data = entry_value & ordi_pkg::INDEX_MASK;
  end

  ordi_color_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (pixel_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (table_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_valid <= 1'b0;
    end else if (pixel_accept) begin
      read_valid <= 1'b1;
    end else if (read_move) begin
      read_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= read_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (read_move) begin
      palette_index <= rd_data & ordi_pkg::INDEX_MASK;
    end
  end

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) table_busy |-> !in_accept
  ) else $error("transaction accepted during table clear");

  a_pixel_reaches_read_stage: assert property (
    @(posedge clk) disable iff (rst) pixel_accept |=> read_valid
  ) else $error("pixel lost between accept and table read");

  a_read_data_held: assert property (
    @(posedge clk) disable iff (rst)
    (read_valid && !read_move) |=> (read_valid && $stable(rd_data))
  ) else $error("table read data changed while waiting for output");

  a_output_from_read_stage: assert property (
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(read_valid)
  ) else $error("result shown without a table read");

endmodule

`default_nettype wire

[rtl/ordi_color_table.sv]
// ----------------------------------------------------------------------------
// ordi_color_table
// Colour-to-palette-index store: one write port, one registered read port,
// and a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ordi_color_table (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ordi_pkg::table_wr_t    wr,
  input  wire logic                   rd_en,
  input  wire ordi_pkg::table_addr_t  rd_addr,
  output ordi_pkg::palette_index_t    rd_data,
  output logic                        busy
);

  ordi_pkg::palette_index_t mem [ordi_pkg::TABLE_DEPTH];
  ordi_pkg::table_addr_t    clear_addr;
  logic                     clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

`default_nettype wire
